@@ rtl/ipv4_source_prefix_firewall_core_macros.svh @@
// Assertion macros shared by the firewall RTL.
// Define NO_ASSERTIONS to compile every use down to nothing.
`ifndef IPV4_SOURCE_PREFIX_FIREWALL_CORE_MACROS_SVH
`define IPV4_SOURCE_PREFIX_FIREWALL_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define IPFW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPFW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IPFW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define IPFW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/ipfw_pkg.sv @@
// Shared types, codes and helper functions of the source-prefix firewall.
// Used by the interfaces, the controller, the datapath and the top level.
package ipfw_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int CNT_W  = 32;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;

    // Item action codes.
    localparam logic ACT_ADD      = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;

    localparam logic [3:0]       IPV4_VERSION = 4'd4;
    localparam logic [LEN_W-1:0] LEN_MIN      = 6'd1;
    localparam logic [LEN_W-1:0] LEN_MAX      = 6'd32;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [LEN_W-1:0]  t_len;

    typedef struct packed {
        logic       action;
        t_addr      address;
        t_len       prefix_length;
        logic [7:0] rule_verdict;
        logic [3:0] ip_version;
    } t_in_beat;

    typedef struct packed {
        logic             [1:0] status;
        logic                   forward;
        logic                   matched;
        logic [CNT_W-1:0]       total_packets;
        logic [CNT_W-1:0]       non_ipv4_packets;
    } t_out_beat;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic skip_scan;
        logic last_issue;
        logic out_free;
    } t_sts;

    // Network mask for a prefix length of 1 to 32.
    function automatic t_addr len_mask(input t_len len);
        t_len sh;
        sh = LEN_MAX - len;
        return {ADDR_W{1'b1}} << sh;
    endfunction

endpackage

@@ rtl/ipfw_if.sv @@
// Valid/ready stream interfaces for the firewall input and result channels.
// Depends on ipfw_pkg for the beat types.
interface ipfw_in_if;
    logic               valid;
    logic               ready;
    ipfw_pkg::t_in_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ipfw_out_if;
    logic                valid;
    logic                ready;
    ipfw_pkg::t_out_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/ipv4_source_prefix_firewall_core.sv @@
// IPv4 source-prefix firewall, top level. One beat is in flight at a time.
// Each beat passes accept, check, a scan of the stored rules with its drain (unless
// skipped) and finish, where the result is committed into the result register. A
// new beat is taken only after the commit; a held result stalls the commit.
// Reset (synchronous, active low) empties the rule table and clears both counters.
`include "ipv4_source_prefix_firewall_core_macros.svh"

module ipv4_source_prefix_firewall_core #(
    parameter int RULE_SLOTS   = 1024,
    parameter int VERDICT_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipfw_in_if.sink     i_in,
    ipfw_out_if.source  o_out
);
    import ipfw_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    // Controller.
    ipfw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath with the rule memory.
    ipfw_dp #(
        .RULE_SLOTS   (RULE_SLOTS),
        .VERDICT_BITS (VERDICT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_payload  (i_in.payload),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_out_payload (o_out.payload)
    );

    assign i_in.ready = in_ready;

    // A result is only committed into a free result register.
    `IPFW_ASSERT_SAME(a_commit_free, i_clk, i_rst_n, cmd.commit, sts.out_free, "busy commit")
    // No new beat is taken while the scan runs.
    `IPFW_ASSERT_SAME(a_no_accept_in_scan, i_clk, i_rst_n, cmd.scan_step, !in_ready, "ready in scan")
    // After an accepted beat the block holds off the next one.
    `IPFW_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in.valid && in_ready, !in_ready, "two beats")
    // A commit always leaves a result waiting on the output.
    `IPFW_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, cmd.commit, o_out.valid, "result not shown")

endmodule

@@ rtl/ipfw_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module ipfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ipfw_ctrl.sv @@
// Sequencing controller of the firewall: accepts a beat, runs the table scan
// and commits the result. Depends on ipfw_pkg for command and status types.
module ipfw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ipfw_pkg::t_sts i_sts,
    output ipfw_pkg::t_cmd o_cmd
);
    import ipfw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_in_ready      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_sts.skip_scan ? S_FINISH : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/ipfw_dp.sv @@
// Datapath of the firewall: item register, rule memory scan, counters and
// the result register. Depends on ipfw_pkg and ipfw_ram.
module ipfw_dp #(
    parameter int RULE_SLOTS   = 1024,
    parameter int VERDICT_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ipfw_pkg::t_in_beat   i_in_payload,
    input  ipfw_pkg::t_cmd       i_cmd,
    output ipfw_pkg::t_sts       o_sts,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ipfw_pkg::t_out_beat  o_out_payload
);
    import ipfw_pkg::*;

    localparam int IW      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CW      = $clog2(RULE_SLOTS + 1);
    localparam int ENTRY_W = ADDR_W + LEN_W + VERDICT_BITS;

    t_in_beat                r_item;
    logic [CW-1:0]           r_rule_cnt;
    logic [CW-1:0]           r_idx;
    logic                    r_eval_vld;
    logic [IW-1:0]           r_eval_idx;
    logic                    r_found;
    logic [IW-1:0]           r_found_idx;
    logic                    r_hit;
    t_len                    r_best_len;
    logic [VERDICT_BITS-1:0] r_best_word;
    logic [CNT_W-1:0]        r_pkt_cnt;
    logic [CNT_W-1:0]        r_bad_cnt;
    logic                    r_out_vld;
    t_out_beat               r_out;

    logic [ENTRY_W-1:0]      rd_entry;
    t_addr                   rd_pfx;
    t_len                    rd_len;
    logic [VERDICT_BITS-1:0] rd_word;
    t_addr                   item_pfx;
    logic [VERDICT_BITS-1:0] item_word;
    logic                    is_add;
    logic                    len_bad;
    logic                    ver_bad;
    logic                    tbl_full;
    logic                    match_add;
    logic                    match_pkt;
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    logic [CNT_W-1:0]        n_pkt_cnt;
    logic [CNT_W-1:0]        n_bad_cnt;
    t_out_beat               n_out;

    // Decode of the held item.
    assign is_add   = (r_item.action == ACT_ADD);
    assign len_bad  = (r_item.prefix_length < LEN_MIN) || (r_item.prefix_length > LEN_MAX);
    assign ver_bad  = (r_item.ip_version != IPV4_VERSION);
    assign tbl_full = (r_rule_cnt == CW'(RULE_SLOTS));
    assign item_pfx = r_item.address & len_mask(r_item.prefix_length);

    // The verdict word keeps its low VERDICT_BITS bits, or is zero-extended when VERDICT_BITS is over 8.
    generate
        if (VERDICT_BITS >= 8) begin : g_word_wide
            assign item_word = VERDICT_BITS'(r_item.rule_verdict);
        end else begin : g_word_narrow
            assign item_word = r_item.rule_verdict[VERDICT_BITS-1:0];
        end
    endgenerate

    // Rule memory: one entry holds prefix, length and verdict word.
    ipfw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RULE_SLOTS)
    ) u_rules (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata ({item_pfx, r_item.prefix_length, item_word}),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (rd_entry)
    );

    assign rd_pfx  = rd_entry[ENTRY_W-1 -: ADDR_W];
    assign rd_len  = rd_entry[VERDICT_BITS +: LEN_W];
    assign rd_word = rd_entry[VERDICT_BITS-1:0];

    // Compare of the entry read last cycle against the held item.
    assign match_add = (rd_len == r_item.prefix_length) && (rd_pfx == item_pfx);
    assign match_pkt = (rd_len > r_best_len) &&
                       ((r_item.address & len_mask(rd_len)) == rd_pfx);

    // Table update at commit: replace a found rule, else append if room.
    assign wr_en   = i_cmd.commit && is_add && !len_bad && (r_found || !tbl_full);
    assign wr_addr = r_found ? r_found_idx : r_rule_cnt[IW-1:0];

    // Result and counters at commit.
    always_comb begin
        n_pkt_cnt = r_pkt_cnt;
        n_bad_cnt = r_bad_cnt;
        n_out     = '0;
        if (is_add) begin
            if (len_bad) begin
                n_out.status = ST_BAD_LEN;
            end else if (!r_found && tbl_full) begin
                n_out.status = ST_FULL;
            end else begin
                n_out.status = ST_OK;
            end
        end else begin
            n_pkt_cnt = r_pkt_cnt + CNT_W'(1);
            if (ver_bad) begin
                n_bad_cnt = r_bad_cnt + CNT_W'(1);
            end else begin
                n_out.matched = r_hit;
                n_out.forward = r_hit && (r_best_word == '0);
            end
            n_out.status = ST_OK;
        end
        n_out.total_packets    = n_pkt_cnt;
        n_out.non_ipv4_packets = n_bad_cnt;
    end

    // Item capture, scan pointer and best-match tracking.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_payload;
        end
        if (i_cmd.scan_step) begin
            r_eval_idx <= r_idx[IW-1:0];
        end
        if (r_eval_vld && match_add && !r_found) begin
            r_found_idx <= r_eval_idx;
        end
        if (r_eval_vld && match_pkt) begin
            r_best_word <= rd_word;
        end
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_eval_vld <= 1'b0;
            r_found    <= 1'b0;
            r_hit      <= 1'b0;
            r_best_len <= '0;
        end else begin
            r_eval_vld <= i_cmd.scan_step;
            if (i_cmd.load) begin
                r_idx      <= '0;
                r_found    <= 1'b0;
                r_hit      <= 1'b0;
                r_best_len <= '0;
            end else begin
                if (i_cmd.scan_step) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (r_eval_vld && match_add) begin
                    r_found <= 1'b1;
                end
                if (r_eval_vld && match_pkt) begin
                    r_hit      <= 1'b1;
                    r_best_len <= rd_len;
                end
            end
        end
    end

    // Counters and the result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            r_rule_cnt <= '0;
            r_pkt_cnt  <= '0;
            r_bad_cnt  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_pkt_cnt <= n_pkt_cnt;
                r_bad_cnt <= n_bad_cnt;
                if (wr_en && !r_found) begin
                    r_rule_cnt <= r_rule_cnt + CW'(1);
                end
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Status back to the controller.
    assign o_sts.skip_scan  = (is_add ? len_bad : ver_bad) || (r_rule_cnt == '0);
    assign o_sts.last_issue = (r_idx == (r_rule_cnt - CW'(1)));
    assign o_sts.out_free   = !r_out_vld || i_out_ready;

    assign o_out_valid   = r_out_vld;
    assign o_out_payload = r_out;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the IPv4 source-prefix firewall core.
// Drives add and classify beats, predicts every result beat and compares them.
// Depends on ipfw_pkg, the ipfw_in_if/ipfw_out_if interfaces and the core RTL.
`timescale 1ns / 1ps

module tb;
    import ipfw_pkg::*;

    localparam int FW_RULES     = 1024;
    localparam int VERDICT_W    = 8;
    localparam int STALL_LIMIT  = 4 * (FW_RULES + 5) + 1000;
    localparam int PHASE_ITEMS  = 190;
    localparam int TAIL_ITEMS   = 180;

    // Rule table mirror, packet counters and the queue of result beats still owed.
    class verdict_board;
        t_addr       rule_pfx  [FW_RULES];
        t_len        rule_len  [FW_RULES];
        logic [7:0]  rule_word [FW_RULES];
        int unsigned rule_total;
        logic [31:0] packets_seen;
        logic [31:0] foreign_seen;
        t_out_beat   pending_verdicts[$];
        int unsigned errors;
        int unsigned adds;
        int unsigned hits;
        int unsigned forwards;
        int unsigned full_rejects;
        int unsigned len_rejects;

        function new();
            rule_total   = 0;
            packets_seen = '0;
            foreign_seen = '0;
            errors       = 0;
            adds         = 0;
            hits         = 0;
            forwards     = 0;
            full_rejects = 0;
            len_rejects  = 0;
        endfunction

        static function t_addr net_mask(input t_len len);
            t_addr ones;
            ones = '1;
            return ones << (32 - len);
        endfunction

        // Applies one beat to the mirrored table and returns the result it must produce.
        function t_out_beat firewall_outcome(input t_in_beat b);
            t_out_beat  r;
            t_addr      pfx;
            t_len       best;
            logic [7:0] best_word;
            bit         found;
            r         = '0;
            r.status  = ST_OK;
            found     = 1'b0;
            best      = '0;
            best_word = '0;
            if (b.action == ACT_ADD) begin
                adds++;
                if (b.prefix_length < LEN_MIN || b.prefix_length > LEN_MAX) begin
                    r.status = ST_BAD_LEN;
                    len_rejects++;
                end else begin
                    pfx = b.address & net_mask(b.prefix_length);
                    for (int i = 0; i < rule_total; i++) begin
                        if (!found && rule_len[i] == b.prefix_length && rule_pfx[i] == pfx) begin
                            rule_word[i] = b.rule_verdict[VERDICT_W-1:0];
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        if (rule_total >= FW_RULES) begin
                            r.status = ST_FULL;
                            full_rejects++;
                        end else begin
                            rule_pfx[rule_total]  = pfx;
                            rule_len[rule_total]  = b.prefix_length;
                            rule_word[rule_total] = b.rule_verdict[VERDICT_W-1:0];
                            rule_total++;
                        end
                    end
                end
            end else begin
                packets_seen++;
                if (b.ip_version != IPV4_VERSION) begin
                    foreign_seen++;
                end else begin
                    // The longest matching prefix wins; a miss drops.
                    for (int i = 0; i < rule_total; i++) begin
                        if (rule_len[i] > best &&
                            (b.address & net_mask(rule_len[i])) == rule_pfx[i]) begin
                            best      = rule_len[i];
                            best_word = rule_word[i];
                            found     = 1'b1;
                        end
                    end
                    r.matched = found;
                    r.forward = found && (best_word == '0);
                    if (found) hits++;
                    if (r.forward) forwards++;
                end
            end
            r.total_packets    = packets_seen;
            r.non_ipv4_packets = foreign_seen;
            return r;
        endfunction

        function void log_request(input t_in_beat b);
            pending_verdicts.push_back(firewall_outcome(b));
        endfunction

        function void check_verdict(input t_out_beat got);
            t_out_beat want;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result beat with none expected, got %h", $time, got);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.forward !== want.forward) begin
                $display("%0t: forward mismatch, expected %0d, got %0d",
                         $time, want.forward, got.forward);
                errors++;
            end
            if (got.matched !== want.matched) begin
                $display("%0t: matched mismatch, expected %0d, got %0d",
                         $time, want.matched, got.matched);
                errors++;
            end
            if (got.total_packets !== want.total_packets) begin
                $display("%0t: total_packets mismatch, expected %0d, got %0d",
                         $time, want.total_packets, got.total_packets);
                errors++;
            end
            if (got.non_ipv4_packets !== want.non_ipv4_packets) begin
                $display("%0t: non_ipv4_packets mismatch, expected %0d, got %0d",
                         $time, want.non_ipv4_packets, got.non_ipv4_packets);
                errors++;
            end
        endfunction
    endclass

    bit   i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   stalled_cycles;
    int   beats_sent;

    verdict_board board;

    ipfw_in_if  in_if ();
    ipfw_out_if out_if ();

    ipv4_source_prefix_firewall_core #(
        .RULE_SLOTS   (FW_RULES),
        .VERDICT_BITS (VERDICT_W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Free-running 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The result side stalls at random; ready changes on the falling edge only.
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Every result beat is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            board.check_verdict(out_if.payload);
        end
    end

    // Give up when neither channel has moved a beat for too long.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, stalled_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    function automatic t_in_beat compose(input logic act, input t_addr addr, input t_len len,
                                         input logic [7:0] word, input logic [3:0] ver);
        t_in_beat b;
        b.action        = act;
        b.address       = addr;
        b.prefix_length = len;
        b.rule_verdict  = word;
        b.ip_version    = ver;
        return b;
    endfunction

    // Random beat: half packets, mostly aimed at stored prefixes, and adds that
    // replace, nest under or extend the stored rules, with some bad lengths.
    function automatic t_in_beat draw_item();
        t_in_beat b;
        int       k;
        int       roll;
        t_addr    host;
        b.address       = $urandom;
        b.prefix_length = t_len'($urandom_range(63));
        b.rule_verdict  = 8'($urandom_range(255));
        b.ip_version    = 4'($urandom_range(15));
        k = (board.rule_total > 0) ? int'($urandom_range(board.rule_total - 1)) : 0;
        if ($urandom_range(99) < 50) begin
            b.action = ACT_CLASSIFY;
            if ($urandom_range(99) < 85) b.ip_version = IPV4_VERSION;
            if (board.rule_total > 0 && $urandom_range(99) < 75) begin
                host      = b.address & ~verdict_board::net_mask(board.rule_len[k]);
                b.address = board.rule_pfx[k] | host;
            end
        end else begin
            b.action = ACT_ADD;
            if ($urandom_range(99) < 40) b.rule_verdict = '0;
            roll = $urandom_range(99);
            if (roll < 12) begin
                if ($urandom_range(3) == 0) b.prefix_length = '0;
                else b.prefix_length = t_len'($urandom_range(63, 33));
            end else if (board.rule_total > 0 && roll < 35) begin
                host            = b.address & ~verdict_board::net_mask(board.rule_len[k]);
                b.address       = board.rule_pfx[k] | host;
                b.prefix_length = board.rule_len[k];
            end else if (board.rule_total > 0 && roll < 60 && board.rule_len[k] < LEN_MAX) begin
                host            = b.address & ~verdict_board::net_mask(board.rule_len[k]);
                b.address       = board.rule_pfx[k] | host;
                b.prefix_length = t_len'($urandom_range(32, board.rule_len[k] + 1));
            end else begin
                b.prefix_length = t_len'($urandom_range(32, 1));
            end
        end
        return b;
    endfunction

    // Presents one beat, idling first at random, and returns on the next falling edge.
    task automatic send_item(input t_in_beat b);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        board.log_request(b);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) send_item(draw_item());
    endtask

    initial begin
        board          = new();
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.payload  = '0;
        out_if.ready   = 1'b0;
        src_idle_pct   = 20;
        sink_idle_pct  = 51;
        stalled_cycles = 0;
        beats_sent     = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats: empty table, bad versions, bad lengths, both extremes
        // of the prefix length, nesting, replacement and a miss after rules exist.
        send_item(compose(ACT_CLASSIFY, 32'hC0A8_0101, 6'd0,  8'h00, IPV4_VERSION));
        send_item(compose(ACT_CLASSIFY, 32'h0000_0000, 6'd63, 8'hFF, 4'd0));
        send_item(compose(ACT_CLASSIFY, 32'hFFFF_FFFF, 6'd32, 8'h5A, 4'd15));
        send_item(compose(ACT_ADD,      32'h0A00_0000, 6'd0,  8'h00, IPV4_VERSION));
        send_item(compose(ACT_ADD,      32'h0A00_0000, 6'd33, 8'h00, 4'd0));
        send_item(compose(ACT_ADD,      32'hFFFF_FFFF, 6'd63, 8'hFF, 4'd15));
        send_item(compose(ACT_ADD,      32'hFFFF_FFFF, 6'd32, 8'h00, 4'd15));
        send_item(compose(ACT_ADD,      32'hFFFF_FFFF, 6'd1,  8'hFF, 4'd0));
        send_item(compose(ACT_CLASSIFY, 32'hFFFF_FFFF, 6'd0,  8'hFF, IPV4_VERSION));
        send_item(compose(ACT_CLASSIFY, 32'h8000_0001, 6'd63, 8'h00, IPV4_VERSION));
        send_item(compose(ACT_ADD,      32'h0A12_3456, 6'd8,  8'h00, IPV4_VERSION));
        send_item(compose(ACT_ADD,      32'h0A01_01FF, 6'd24, 8'h01, IPV4_VERSION));
        send_item(compose(ACT_CLASSIFY, 32'h0A01_0105, 6'd12, 8'h33, IPV4_VERSION));
        send_item(compose(ACT_CLASSIFY, 32'h0A02_0304, 6'd12, 8'h33, IPV4_VERSION));
        send_item(compose(ACT_ADD,      32'h0A01_0100, 6'd24, 8'h00, 4'd6));
        send_item(compose(ACT_CLASSIFY, 32'h0A01_01AA, 6'd24, 8'h01, IPV4_VERSION));
        send_item(compose(ACT_CLASSIFY, 32'h0000_0000, 6'd0,  8'h00, IPV4_VERSION));
        send_item(compose(ACT_ADD,      32'h0000_0000, 6'd1,  8'h80, IPV4_VERSION));
        send_item(compose(ACT_CLASSIFY, 32'h0000_0000, 6'd0,  8'h00, IPV4_VERSION));
        send_item(compose(ACT_CLASSIFY, 32'h7FFF_FFFF, 6'd0,  8'h00, IPV4_VERSION));
        send_item(compose(ACT_CLASSIFY, 32'h0A01_0101, 6'd24, 8'h00, 4'd6));

        // Random traffic under three idling patterns.
        send_random(PHASE_ITEMS);
        src_idle_pct  = 51;
        sink_idle_pct = 20;
        send_random(PHASE_ITEMS);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random(TAIL_ITEMS);
        in_if.valid <= 1'b0;

        // Drain, then leave room for any stray result beat.
        while (board.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (FW_RULES + 10) @(posedge i_clk);

        $display("Sent %0d beats: %0d adds, %0d packets (%0d non-IPv4), %0d rules stored.",
                 beats_sent, board.adds, board.packets_seen, board.foreign_seen,
                 board.rule_total);
        $display("Packets matched %0d, forwarded %0d; adds rejected full %0d, bad length %0d.",
                 board.hits, board.forwards, board.full_rejects, board.len_rejects);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
